@@ src/upr_pkg.sv @@
package upr_pkg;

   // packet geometry
   localparam int PACKET_BYTES  = 130;
   localparam int PAYLOAD_BYTES = 128;
   localparam int IMAGE_BYTES   = 16384;

   // field widths
   localparam int LEN_W    = 31;
   localparam int DATA_W   = 8;
   localparam int ADDR_W   = 14;
   localparam int PKT_W    = 16;
   localparam int STATUS_W = 3;
   localparam int BYTE_W   = 8;
   localparam int XOR_W    = 8;
   localparam int REM_W    = 32;
   localparam int BASE_W   = 32;
   localparam int MAXLEN_W = 15;
   localparam int OFF_W    = $clog2(65536 * PAYLOAD_BYTES + IMAGE_BYTES + 1);

   // stream packing
   localparam int REQ_FIELDS_W = LEN_W + DATA_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = ADDR_W + DATA_W + PKT_W + STATUS_W + 1;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_TUSER_W  = 2;
   localparam int TUSER_WRITE  = 0;
   localparam int TUSER_ACK    = 1;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_BASE_ADDRESS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_IMAGE_LENGTH   = 1'd1;
   localparam logic [MAXLEN_W-1:0]    MAX_IMAGE_LENGTH_RESET = 15'd16384;

   // queue depths
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   typedef enum logic {
      CMD_START,
      CMD_BYTE
   } cmd_kind_type;

   typedef enum logic {
      PHASE_IDLE,
      PHASE_RECV
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_PACKET_LENGTH,
      STATUS_CHECK,
      STATUS_OVERFLOW,
      STATUS_ADDRESS,
      STATUS_FORMAT,
      STATUS_LENGTH_MISMATCH
   } status_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [LEN_W-1:0]  image_length;
      logic [DATA_W-1:0] data_byte;
      logic              gap_after;
   } cmd_type;

   typedef struct packed {
      logic              write_valid;
      logic [ADDR_W-1:0] write_address;
      logic [DATA_W-1:0] write_data;
      logic              ack_valid;
      logic [PKT_W-1:0]  packet_number;
      status_type        status;
      logic              session_done;
      logic              last_of_run;
   } rsp_type;

   // signature "TA01" expected at bytes 4..7 of the first packet
   function automatic logic [DATA_W-1:0] sig_byte(input logic [1:0] idx);
      logic [DATA_W-1:0] value;
      case (idx)
         2'd0: value = 8'h54;
         2'd1: value = 8'h41;
         2'd2: value = 8'h30;
         2'd3: value = 8'h31;
         default: value = 8'h00;
      endcase
      return value;
   endfunction

endpackage

@@ src/upr_front.sv @@
module upr_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [upr_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   input  logic                            req_tlast,
   output logic                            cmd_valid,
   output upr_pkg::cmd_type                cmd,
   input  logic                            cmd_pop
);
   import upr_pkg::*;

   cmd_type              mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   cmd_type              decoded;
   logic                 push;

   // classify the item and unpack its fields
   always_comb begin
      decoded.kind         = req_tuser ? CMD_BYTE : CMD_START;
      decoded.image_length = req_tdata[LEN_W-1:0];
      decoded.data_byte    = req_tdata[LEN_W +: DATA_W];
      decoded.gap_after    = req_tlast;
   end

   assign req_tready = (count_ff != CMD_CNT_W'(CMD_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != '0);
   assign cmd        = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + CMD_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + CMD_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CMD_CNT_W'(push) - CMD_CNT_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

@@ src/upr_back.sv @@
module upr_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [upr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [upr_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                            cmd_valid,
   input  upr_pkg::cmd_type                cmd,
   output logic                            cmd_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output upr_pkg::rsp_type                rsp
);
   import upr_pkg::*;

   logic [BASE_W-1:0]   base_cfg_ff;
   logic [MAXLEN_W-1:0] max_len_cfg_ff;

   phase_type           phase_ff, phase_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic [XOR_W-1:0]    xor_ff, xor_in;
   logic [PKT_W-1:0]    count_ff, count_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic                sig_ff, sig_in;
   logic [BASE_W-1:0]   addr_ff, addr_in;
   logic [LEN_W-1:0]    ann_ff, ann_in;
   logic [OFF_W-1:0]    off_base_ff, off_base_in;

   rsp_type             out_mem_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] out_wr_ff, out_wr_in;
   logic [OUT_PTR_W-1:0] out_rd_ff, out_rd_in;
   logic [OUT_CNT_W-1:0] out_cnt_ff, out_cnt_in;

   rsp_type             wr_res, ack_res, slot0;
   logic                wr_en, ack_en;
   logic [1:0]          n_wr;
   logic                out_pop;

   // room for the two results one item can cause
   assign cmd_pop   = cmd_valid && (out_cnt_ff <= OUT_CNT_W'(OUT_DEPTH - 2));
   assign rsp_valid = (out_cnt_ff != '0);
   assign rsp       = out_mem_ff[out_rd_ff];
   assign out_pop   = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_cfg_ff    <= '0;
         max_len_cfg_ff <= MAX_IMAGE_LENGTH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_BASE_ADDRESS: base_cfg_ff <= csr_write_data[BASE_W-1:0];
            CSR_MAX_IMAGE_LENGTH:   max_len_cfg_ff <= csr_write_data[MAXLEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [BYTE_W-1:0] b;
      logic [BYTE_W:0]   nb;
      logic [XOR_W-1:0]  xor_new;
      logic [OFF_W-1:0]  off;
      logic [PKT_W-1:0]  count_new;
      logic [REM_W-1:0]  rem_dec;
      status_type        st;
      logic              done;

      phase_in    = phase_ff;
      byte_in     = byte_ff;
      xor_in      = xor_ff;
      count_in    = count_ff;
      rem_in      = rem_ff;
      sig_in      = sig_ff;
      addr_in     = addr_ff;
      ann_in      = ann_ff;
      off_base_in = off_base_ff;
      wr_res      = '0;
      ack_res     = '0;
      wr_en       = 1'b0;
      ack_en      = 1'b0;

      b         = byte_ff;
      nb        = {1'b0, b} + (BYTE_W + 1)'(1);
      xor_new   = xor_ff ^ cmd.data_byte;
      off       = off_base_ff + OFF_W'(b);
      count_new = count_ff + PKT_W'(1);
      rem_dec   = rem_ff - REM_W'(PAYLOAD_BYTES);
      st        = STATUS_OK;
      done      = 1'b0;

      if (cmd_pop) begin
         if (cmd.kind == CMD_START) begin
            ann_in      = cmd.image_length;
            rem_in      = REM_W'(cmd.image_length);
            count_in    = '0;
            byte_in     = '0;
            xor_in      = '0;
            sig_in      = 1'b1;
            addr_in     = '0;
            off_base_in = '0;
            phase_in    = PHASE_RECV;
            ack_en      = 1'b1;
         end else if (phase_ff == PHASE_RECV) begin
            xor_in = xor_new;
            if (count_ff == '0) begin
               if (b >= BYTE_W'(4) && b <= BYTE_W'(7) &&
                   cmd.data_byte != sig_byte(b[1:0])) begin
                  sig_in = 1'b0;
               end
               if (b >= BYTE_W'(8) && b <= BYTE_W'(11)) begin
                  addr_in[{b[1:0], 3'b000} +: 8] = cmd.data_byte;
               end
            end
            if (b < BYTE_W'(PAYLOAD_BYTES) && off < OFF_W'(IMAGE_BYTES)) begin
               wr_en                = 1'b1;
               wr_res.write_valid   = 1'b1;
               wr_res.write_address = off[ADDR_W-1:0];
               wr_res.write_data    = cmd.data_byte;
            end
            if (nb < (BYTE_W + 1)'(PACKET_BYTES)) begin
               if (cmd.gap_after) begin
                  // packet cut short
                  ack_en                = 1'b1;
                  ack_res.packet_number = count_new;
                  ack_res.status        = STATUS_PACKET_LENGTH;
                  phase_in              = PHASE_IDLE;
                  byte_in               = '0;
               end else begin
                  byte_in = nb[BYTE_W-1:0];
               end
            end else begin
               byte_in     = '0;
               count_in    = count_new;
               off_base_in = (count_ff == '1) ? '0 : off_base_ff + OFF_W'(PAYLOAD_BYTES);
               if (xor_new != '0) begin
                  st = STATUS_CHECK;
               end else if (count_new == PKT_W'(1) && !sig_in) begin
                  st = STATUS_FORMAT;
               end else if (count_new == PKT_W'(1) && addr_in != base_cfg_ff) begin
                  st = STATUS_ADDRESS;
               end else if (count_new == PKT_W'(1) &&
                            ann_ff > LEN_W'(max_len_cfg_ff)) begin
                  st = STATUS_OVERFLOW;
               end
               xor_in = '0;
               if (st == STATUS_OK) begin
                  rem_in = rem_dec;
                  if (rem_dec == '0) begin
                     done = 1'b1;
                  end else if (rem_dec[REM_W-1]) begin
                     st = STATUS_LENGTH_MISMATCH;
                  end
               end
               if (st != STATUS_OK || done) begin
                  phase_in = PHASE_IDLE;
               end
               ack_en                = 1'b1;
               ack_res.packet_number = count_new;
               ack_res.status        = st;
               ack_res.session_done  = done;
            end
         end
      end

      ack_res.ack_valid   = 1'b1;
      ack_res.last_of_run = 1'b1;
      wr_res.last_of_run  = !ack_en;
      slot0               = wr_en ? wr_res : ack_res;
      n_wr                = {1'b0, wr_en} + {1'b0, ack_en};

      out_wr_in  = out_wr_ff + OUT_PTR_W'(n_wr);
      out_rd_in  = out_pop ? out_rd_ff + OUT_PTR_W'(1) : out_rd_ff;
      out_cnt_in = out_cnt_ff + OUT_CNT_W'(n_wr) - OUT_CNT_W'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_IDLE;
         byte_ff     <= '0;
         xor_ff      <= '0;
         count_ff    <= '0;
         rem_ff      <= '0;
         sig_ff      <= 1'b1;
         addr_ff     <= '0;
         ann_ff      <= '0;
         off_base_ff <= '0;
         out_wr_ff   <= '0;
         out_rd_ff   <= '0;
         out_cnt_ff  <= '0;
      end else begin
         phase_ff    <= phase_in;
         byte_ff     <= byte_in;
         xor_ff      <= xor_in;
         count_ff    <= count_in;
         rem_ff      <= rem_in;
         sig_ff      <= sig_in;
         addr_ff     <= addr_in;
         ann_ff      <= ann_in;
         off_base_ff <= off_base_in;
         out_wr_ff   <= out_wr_in;
         out_rd_ff   <= out_rd_in;
         out_cnt_ff  <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_wr != 2'd0) begin
         out_mem_ff[out_wr_ff] <= slot0;
      end
      if (n_wr == 2'd2) begin
         out_mem_ff[out_wr_ff + OUT_PTR_W'(1)] <= ack_res;
      end
   end

endmodule

@@ src/upgrade_packet_receiver.sv @@
// Firmware upgrade receiver.
// req channel: one item per start command (tuser 0, image length in tdata) or per
// received packet byte (tuser 1, byte in tdata, tlast set when reception paused).
// rsp channel: image writes (tuser bit 0) and acknowledgements (tuser bit 1);
// tlast marks the last result caused by one request item.
// csr port: write enable, index and data; the user must write it only while the block
// is idle, and the block itself does not enforce this. An accepted item is stored in
// the command queue, and the engine moves its results into the result queue for rsp.
// Throughput: one item per cycle while rsp keeps up; a payload byte that a gap cuts
// short puts out a write and an ack, so the result queue can fill and stall the engine.
// The figure is set by the single-pass per-byte engine and its output queue.
// A four-entry command queue separates intake from the engine, and a four-entry
// result queue separates the engine from rsp; when rsp stalls the engine stops once
// more than two results wait, then the command queue fills and req_tready drops.
// Reset clears both queues, returns the session to idle and loads the register
// reset values; there is no clearing pass, items are taken the cycle after.
module upgrade_packet_receiver (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [upr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [upr_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // image_length, data_byte, zero fill
   input  logic [upr_pkg::REQ_TDATA_W-1:0] req_tdata,
   // op
   input  logic                            req_tuser,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // write_address, write_data, packet_number, status, session_done, zero fill
   output logic [upr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // write_valid, ack_valid
   output logic [upr_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   output logic                            rsp_tlast
);
   import upr_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;
   rsp_type rsp;

   upr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   upr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp              (rsp)
   );

   assign rsp_tdata = RSP_TDATA_W'({rsp.session_done, rsp.status, rsp.packet_number,
                                    rsp.write_data, rsp.write_address});
   assign rsp_tuser = {rsp.ack_valid, rsp.write_valid};
   assign rsp_tlast = rsp.last_of_run;

`ifndef SYNTH
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !cmd_valid)
      else $error("queues not empty after reset");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("engine took from an empty command queue");

   a_ack_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[TUSER_ACK] |-> rsp_tlast && !rsp_tuser[TUSER_WRITE])
      else $error("acknowledgement not marked last or mixed with a write");
`endif

endmodule
